// File: rtl/i2csb_pkg.sv
// ----------------------------------------------------------------------------
// i2csb_pkg
// Shared types and constants for the byte-level I2C slave sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2csb_pkg;

    // Bus event codes carried on the input channel.
    localparam logic [1:0] OP_START    = 2'd0;
    localparam logic [1:0] OP_OVERFLOW = 2'd1;
    localparam logic [1:0] OP_STOP     = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_OWN_ADDRESS     = 2'd0;
    localparam logic [1:0] CFG_BUFFER_CAPACITY = 2'd1;
    localparam logic [1:0] CFG_RECEIVE_ENABLED = 2'd2;
    localparam logic [1:0] CFG_SEND_ENABLED    = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [6:0] RST_OWN_ADDRESS     = 7'd0;
    localparam logic [7:0] RST_BUFFER_CAPACITY = 8'd32;

    // Byte sent on a read when sending is disabled (send_enabled clear).
    localparam logic [7:0] FILLER_BYTE = 8'hCD;

    // Shift lengths requested from the shift unit.
    localparam logic [3:0] BITS_BYTE = 4'd8;
    localparam logic [3:0] BITS_ACK  = 4'd1;

    // Acknowledge bit values.
    localparam logic ACK_BIT  = 1'b0;
    localparam logic NACK_BIT = 1'b1;

    // Receive count meaning "no packet open".
    localparam logic signed [8:0] COUNT_CLOSED = -9'sd1;

    // Protocol phase, one-hot.
    typedef enum logic [6:0] {
        PH_IDLE      = 7'b000_0001,
        PH_ADDR      = 7'b000_0010,
        PH_SEND      = 7'b000_0100,
        PH_REQ_REPLY = 7'b000_1000,
        PH_CHK_REPLY = 7'b001_0000,
        PH_RX_WAIT   = 7'b010_0000,
        PH_RX_ACK    = 7'b100_0000
    } t_phase;

    // Configuration register set.
    typedef struct packed {
        logic [6:0] own_address;
        logic [7:0] buffer_capacity;
        logic       receive_enabled;
        logic       send_enabled;
    } t_cfg;

    // One result beat.
    typedef struct packed {
        logic [7:0] load_byte;
        logic       sda_drive;
        logic [3:0] bits_wanted;
        logic       bus_idle;
        logic       store_valid;
        logic [7:0] store_index;
        logic [7:0] store_byte;
        logic       packet_done;
        logic [7:0] packet_length;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/i2csb_cfg_regs.sv
// ----------------------------------------------------------------------------
// i2csb_cfg_regs
// Configuration register bank written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module i2csb_cfg_regs
    import i2csb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    output t_cfg            o_cfg
);

    t_cfg r_cfg;

    // Register writes; an index selects one register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_address     <= RST_OWN_ADDRESS;
            r_cfg.buffer_capacity <= RST_BUFFER_CAPACITY;
            r_cfg.receive_enabled <= 1'b0;
            r_cfg.send_enabled    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OWN_ADDRESS:     r_cfg.own_address     <= i_cfg_data[6:0];
                CFG_BUFFER_CAPACITY: r_cfg.buffer_capacity <= i_cfg_data;
                CFG_RECEIVE_ENABLED: r_cfg.receive_enabled <= i_cfg_data[0];
                CFG_SEND_ENABLED:    r_cfg.send_enabled    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/i2csb_core.sv
// ----------------------------------------------------------------------------
// i2csb_core
// Protocol state and receive count, with the next-state and result logic for
// one bus event.
// ----------------------------------------------------------------------------
`default_nettype none

module i2csb_core
    import i2csb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [1:0] i_op,
    input  wire logic [7:0] i_shift_data,
    input  wire logic [7:0] i_send_byte,
    input  wire logic       i_buffer_free,
    input  wire t_cfg       i_cfg,
    output logic            o_has_result,
    output t_result         o_result
);

    t_phase               r_phase;
    t_phase               n_phase;
    logic signed [8:0]    r_count;
    logic signed [8:0]    n_count;
    logic [6:0]           addr;
    logic [7:0]           read_byte;
    logic                 count_open;

    assign addr       = i_shift_data[7:1];
    assign read_byte  = i_cfg.send_enabled ? i_send_byte : FILLER_BYTE;
    assign count_open = ~r_count[8];

    // Event decode: next phase, next count and the result beat.
    always_comb begin
        n_phase      = r_phase;
        n_count      = r_count;
        o_has_result = 1'b1;
        o_result     = '0;
        o_result.bits_wanted = BITS_BYTE;

        case (i_op)
            OP_START: begin
                n_phase = PH_ADDR;
            end
            OP_STOP: begin
                if (count_open && (r_count != 9'sd0) && i_cfg.receive_enabled) begin
                    o_result.packet_done   = 1'b1;
                    o_result.packet_length = r_count[7:0];
                end
                n_count           = COUNT_CLOSED;
                n_phase           = PH_IDLE;
                o_result.bus_idle = 1'b1;
            end
            OP_OVERFLOW: begin
                case (r_phase)
                    PH_ADDR: begin
                        if ((addr != 7'd0) && (addr != i_cfg.own_address)) begin
                            n_phase           = PH_IDLE;
                            o_result.bus_idle = 1'b1;
                        end else if (i_shift_data[0]) begin
                            n_phase              = PH_SEND;
                            o_result.sda_drive   = 1'b1;
                            o_result.bits_wanted = BITS_ACK;
                        end else begin
                            o_result.load_byte = {7'd0, NACK_BIT};
                            if (i_cfg.receive_enabled && i_buffer_free
                                    && (r_count == COUNT_CLOSED)) begin
                                n_count            = 9'sd0;
                                o_result.load_byte = {7'd0, ACK_BIT};
                            end
                            n_phase              = PH_RX_WAIT;
                            o_result.sda_drive   = 1'b1;
                            o_result.bits_wanted = BITS_ACK;
                        end
                    end
                    PH_RX_WAIT: begin
                        n_phase = PH_RX_ACK;
                    end
                    PH_RX_ACK: begin
                        o_result.load_byte = {7'd0, NACK_BIT};
                        if (count_open) begin
                            // Buffer full: drop the packet and nack the byte.
                            if (r_count[7:0] >= i_cfg.buffer_capacity) begin
                                n_count = COUNT_CLOSED;
                            end else begin
                                o_result.store_valid = 1'b1;
                                o_result.store_index = r_count[7:0];
                                o_result.store_byte  = i_shift_data;
                                n_count              = r_count + 9'sd1;
                                o_result.load_byte   = {7'd0, ACK_BIT};
                            end
                        end
                        n_phase              = PH_RX_WAIT;
                        o_result.sda_drive   = 1'b1;
                        o_result.bits_wanted = BITS_ACK;
                    end
                    PH_REQ_REPLY: begin
                        n_phase              = PH_CHK_REPLY;
                        o_result.bits_wanted = BITS_ACK;
                    end
                    PH_CHK_REPLY: begin
                        if (i_shift_data != 8'd0) begin
                            n_phase           = PH_IDLE;
                            o_result.bus_idle = 1'b1;
                        end else begin
                            n_phase            = PH_REQ_REPLY;
                            o_result.load_byte = read_byte;
                            o_result.sda_drive = 1'b1;
                        end
                    end
                    PH_SEND: begin
                        n_phase            = PH_REQ_REPLY;
                        o_result.load_byte = read_byte;
                        o_result.sda_drive = 1'b1;
                    end
                    default: begin
                        // Overflow while idle is ignored.
                        o_has_result = 1'b0;
                    end
                endcase
            end
            default: begin
                o_has_result = 1'b0;
            end
        endcase
    end

    // State update on every accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= COUNT_CLOSED;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: rtl/i2csb_out_reg.sv
// ----------------------------------------------------------------------------
// i2csb_out_reg
// Result register with valid/ready handshake; it takes a new beat in the
// cycle the held one leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module i2csb_out_reg
    import i2csb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_out_ready,
    output logic         o_space,
    output logic         o_out_valid,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    // Room for a new beat when empty or the held one is taken now.
    assign o_space = ~r_valid | i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

`default_nettype wire

// File: rtl/i2c_slave_byte_sequencer_unit.sv
// ----------------------------------------------------------------------------
// i2c_slave_byte_sequencer_unit
// Byte-level I2C slave sequencer: turns bus events into shift-unit commands,
// buffer stores and packet reports.
//
//   Channel  | Handshake                 | Beat contents
//   ---------+---------------------------+-----------------------------------
//   input    | i_in_valid / o_in_ready   | op, shift_data, send_byte,
//            |                           | buffer_free
//   output   | o_out_valid / i_out_ready | load_byte ... packet_length
//   config   | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// Each event is decoded combinationally: the phase and receive count update at
// the accepting edge and the result appears in the output register on the
// next cycle. One event per cycle is sustained while the output is drained.
// A stalled output blocks input only when the result register is full.
// Events that cause no result are accepted and produce no output beat.
// Synchronous reset returns the block to idle with no packet open.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_slave_byte_sequencer_unit
    import i2csb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration write port
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    // Input channel
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_op,
    input  wire logic [7:0] i_shift_data,
    input  wire logic [7:0] i_send_byte,
    input  wire logic       i_buffer_free,
    // Output channel
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_load_byte,
    output logic            o_sda_drive,
    output logic [3:0]      o_bits_wanted,
    output logic            o_bus_idle,
    output logic            o_store_valid,
    output logic [7:0]      o_store_index,
    output logic [7:0]      o_store_byte,
    output logic            o_packet_done,
    output logic [7:0]      o_packet_length
);

    t_cfg    cfg;
    t_result core_result;
    t_result out_result;
    logic    has_result;
    logic    accept;
    logic    space;

    assign o_in_ready = space;
    assign accept     = i_in_valid & space;

    i2csb_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    i2csb_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_op          (i_op),
        .i_shift_data  (i_shift_data),
        .i_send_byte   (i_send_byte),
        .i_buffer_free (i_buffer_free),
        .i_cfg         (cfg),
        .o_has_result  (has_result),
        .o_result      (core_result)
    );

    i2csb_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept & has_result),
        .i_result    (core_result),
        .i_out_ready (i_out_ready),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    // Result fields onto their ports.
    assign o_load_byte     = out_result.load_byte;
    assign o_sda_drive     = out_result.sda_drive;
    assign o_bits_wanted   = out_result.bits_wanted;
    assign o_bus_idle      = out_result.bus_idle;
    assign o_store_valid   = out_result.store_valid;
    assign o_store_index   = out_result.store_index;
    assign o_store_byte    = out_result.store_byte;
    assign o_packet_done   = out_result.packet_done;
    assign o_packet_length = out_result.packet_length;

endmodule

`default_nettype wire
